// ----- src/wcdp_pkg.sv -----
// ----------------------------------------------------------------------------
// wcdp_pkg
// Types, constants and helpers shared by the WebP chunk dimension parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wcdp_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;

    // result queue
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // result kinds
    localparam logic [1:0] KIND_DIMS    = 2'd0;
    localparam logic [1:0] KIND_EXIF    = 2'd1;
    localparam logic [1:0] KIND_NO_EXIF = 2'd2;

    // chunk tags, first byte in the high bits
    localparam logic [31:0] TAG_VP8   = 32'h5650_3820;
    localparam logic [31:0] TAG_VP8L  = 32'h5650_384C;
    localparam logic [31:0] TAG_VP8X  = 32'h5650_3858;
    localparam logic [31:0] TAG_EXIF  = 32'h4558_4946;
    // "Exif" as a little-endian word
    localparam logic [31:0] WORD_EXIF = 32'h6669_7845;

    localparam logic [13:0] MASK14 = 14'h3FFF;

    // byte counts per phase
    localparam logic [3:0] HDR_BYTES  = 4'd12;
    localparam logic [3:0] TAG_BYTES  = 4'd4;
    localparam logic [3:0] VP8_BYTES  = 4'd10;
    localparam logic [3:0] VP8L_BYTES = 4'd5;
    localparam logic [3:0] VP8X_BYTES = 4'd10;

    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_TAG  = 3'd1,
        PH_SIZE = 3'd2,
        PH_VP8  = 3'd3,
        PH_VP8L = 3'd4,
        PH_VP8X = 3'd5,
        PH_EXIF = 3'd6,
        PH_SKIP = 3'd7
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [24:0] width;
        logic [24:0] height;
        logic [31:0] offset;
        logic        prefixed;
        logic        last;
    } result_t;

    // up to two results from one byte, first in r0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    // bytes left to skip in a chunk: remaining payload plus the pad byte of an odd size
    function automatic logic [32:0] skip_amount(input logic [31:0] len,
                                                input logic [3:0]  consumed);
        logic [32:0] rest;
        rest = (len > {28'd0, consumed}) ? {1'b0, len - {28'd0, consumed}} : 33'd0;
        return rest + {32'd0, len[0]};
    endfunction

    function automatic result_t make_result(input logic [1:0]  kind,
                                            input logic [24:0] width,
                                            input logic [24:0] height,
                                            input logic [31:0] offset,
                                            input logic        prefixed);
        result_t r;
        r.kind     = kind;
        r.width    = width;
        r.height   = height;
        r.offset   = offset;
        r.prefixed = prefixed;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/wcdp_parser.sv -----
// ----------------------------------------------------------------------------
// wcdp_parser
// Input register plus the chunk walker: one byte per cycle in, up to two
// result words per byte out to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wcdp_parser
    import wcdp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_start,
    input  wire logic       in_end,
    output push_t           push
);

    logic                   valid_reg;
    logic [7:0]             byte_reg;
    logic                   start_reg;
    logic                   end_reg;

    phase_t                 phase_reg,  phase_next;
    logic [3:0]             count_reg,  count_next;
    logic [31:0]            tag_reg,    tag_next;
    logic [31:0]            len_reg,    len_next;
    logic [32:0]            skip_reg,   skip_next;
    logic [47:0]            fb_reg,     fb_next;
    logic [OFFSET_BITS-1:0] pos_reg,    pos_next;
    logic                   dims_reg,   dims_next;
    logic                   done_reg,   done_next;

    logic [32:0]            amt;
    logic                   pre;
    logic [31:0]            vp8l_bits;
    logic [OFFSET_BITS-1:0] off_w;
    logic [OFFSET_BITS+31:0] off_ext;
    logic [3:0]             cnt_inc;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            byte_reg  <= in_byte;
            start_reg <= in_start;
            end_reg   <= in_end;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        skip_next  = skip_reg;
        fb_next    = fb_reg;
        pos_next   = pos_reg;
        dims_next  = dims_reg;
        done_next  = done_reg;
        amt        = 33'd0;
        pre        = 1'b0;
        vp8l_bits  = 32'd0;
        off_w      = '0;
        off_ext    = '0;
        cnt_inc    = 4'd0;
        push       = '0;

        if (valid_reg)
        begin
            if (start_reg)
            begin
                phase_next = PH_HDR;
                count_next = 4'd0;
                tag_next   = 32'd0;
                len_next   = 32'd0;
                skip_next  = 33'd0;
                fb_next    = 48'd0;
                pos_next   = '0;
                dims_next  = 1'b0;
                done_next  = 1'b0;
            end

            if (!done_next)
            begin
                fb_next  = {byte_reg, fb_next[47:8]};
                pos_next = pos_next + OFFSET_BITS'(1);
                cnt_inc  = count_next + 4'd1;
                unique case (phase_next)
                    PH_HDR:
                    begin
                        count_next = cnt_inc;
                        if (cnt_inc >= HDR_BYTES)
                        begin
                            count_next = 4'd0;
                            phase_next = PH_TAG;
                        end
                    end
                    PH_TAG:
                    begin
                        tag_next   = {tag_next[23:0], byte_reg};
                        count_next = cnt_inc;
                        if (cnt_inc >= TAG_BYTES)
                        begin
                            count_next = 4'd0;
                            phase_next = PH_SIZE;
                        end
                    end
                    PH_SIZE:
                    begin
                        len_next   = {byte_reg, len_next[31:8]};
                        count_next = cnt_inc;
                        if (cnt_inc >= TAG_BYTES)
                        begin
                            // dispatch on the tag
                            count_next = 4'd0;
                            fb_next    = 48'd0;
                            if (tag_next == TAG_VP8 && !dims_next)
                            begin
                                phase_next = PH_VP8;
                            end
                            else if (tag_next == TAG_VP8L && !dims_next)
                            begin
                                phase_next = PH_VP8L;
                            end
                            else if (tag_next == TAG_VP8X && !dims_next)
                            begin
                                phase_next = PH_VP8X;
                            end
                            else if (tag_next == TAG_EXIF)
                            begin
                                phase_next = PH_EXIF;
                            end
                            else
                            begin
                                amt        = skip_amount(len_next, 4'd0);
                                skip_next  = amt;
                                phase_next = (amt != 33'd0) ? PH_SKIP : PH_TAG;
                            end
                        end
                    end
                    PH_VP8:
                    begin
                        count_next = cnt_inc;
                        if (cnt_inc >= VP8_BYTES)
                        begin
                            push.v0 = 1'b1;
                            push.r0 = make_result(KIND_DIMS,
                                                  {11'd0, fb_next[29:16] & MASK14},
                                                  {11'd0, fb_next[45:32] & MASK14},
                                                  32'd0, 1'b0);
                            dims_next  = 1'b1;
                            amt        = skip_amount(len_next, VP8_BYTES);
                            count_next = 4'd0;
                            skip_next  = amt;
                            phase_next = (amt != 33'd0) ? PH_SKIP : PH_TAG;
                        end
                    end
                    PH_VP8L:
                    begin
                        count_next = cnt_inc;
                        if (cnt_inc >= VP8L_BYTES)
                        begin
                            vp8l_bits = fb_next[47:16];
                            push.v0 = 1'b1;
                            push.r0 = make_result(KIND_DIMS,
                                                  {11'd0, vp8l_bits[13:0]} + 25'd1,
                                                  {11'd0, vp8l_bits[27:14]} + 25'd1,
                                                  32'd0, 1'b0);
                            dims_next  = 1'b1;
                            amt        = skip_amount(len_next, VP8L_BYTES);
                            count_next = 4'd0;
                            skip_next  = amt;
                            phase_next = (amt != 33'd0) ? PH_SKIP : PH_TAG;
                        end
                    end
                    PH_VP8X:
                    begin
                        count_next = cnt_inc;
                        if (cnt_inc >= VP8X_BYTES)
                        begin
                            push.v0 = 1'b1;
                            push.r0 = make_result(KIND_DIMS,
                                                  {1'b0, fb_next[23:0]} + 25'd1,
                                                  {1'b0, fb_next[47:24]} + 25'd1,
                                                  32'd0, 1'b0);
                            dims_next  = 1'b1;
                            amt        = skip_amount(len_next, VP8X_BYTES);
                            count_next = 4'd0;
                            skip_next  = amt;
                            phase_next = (amt != 33'd0) ? PH_SKIP : PH_TAG;
                        end
                    end
                    PH_EXIF:
                    begin
                        count_next = cnt_inc;
                        if (cnt_inc >= TAG_BYTES)
                        begin
                            pre     = (fb_next[47:16] == WORD_EXIF);
                            // TIFF header sits after the prefix and its two pad bytes
                            off_w   = pos_next - OFFSET_BITS'(4)
                                      + (pre ? OFFSET_BITS'(6) : OFFSET_BITS'(0));
                            off_ext = {32'd0, off_w};
                            push.v0 = 1'b1;
                            push.r0 = make_result(KIND_EXIF, 25'd0, 25'd0,
                                                  off_ext[31:0], pre);
                            done_next = 1'b1;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (skip_next != 33'd0)
                        begin
                            skip_next = skip_next - 33'd1;
                        end
                        if (skip_next == 33'd0)
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                endcase
            end

            if (end_reg)
            begin
                if (!done_next)
                begin
                    if (phase_next == PH_EXIF)
                    begin
                        off_w   = pos_next - OFFSET_BITS'(count_next);
                        off_ext = {32'd0, off_w};
                        push.r1 = make_result(KIND_EXIF, 25'd0, 25'd0,
                                              off_ext[31:0], 1'b0);
                    end
                    else
                    begin
                        push.r1 = make_result(KIND_NO_EXIF, 25'd0, 25'd0,
                                              32'd0, 1'b0);
                    end
                    // end-of-file result follows a dimension result if there is one
                    if (push.v0)
                    begin
                        push.v1 = 1'b1;
                    end
                    else
                    begin
                        push.v0 = 1'b1;
                        push.r0 = push.r1;
                        push.r1 = '0;
                    end
                end
                phase_next = PH_HDR;
                count_next = 4'd0;
                tag_next   = 32'd0;
                len_next   = 32'd0;
                skip_next  = 33'd0;
                fb_next    = 48'd0;
                pos_next   = '0;
                dims_next  = 1'b0;
                done_next  = 1'b0;
            end

            // mark the final word of this byte
            if (push.v1)
            begin
                push.r1.last = 1'b1;
            end
            else if (push.v0)
            begin
                push.r0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            count_reg <= 4'd0;
            tag_reg   <= 32'd0;
            len_reg   <= 32'd0;
            skip_reg  <= 33'd0;
            fb_reg    <= 48'd0;
            pos_reg   <= '0;
            dims_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
            fb_reg    <= fb_next;
            pos_reg   <= pos_next;
            dims_reg  <= dims_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/wcdp_result_fifo.sv -----
// ----------------------------------------------------------------------------
// wcdp_result_fifo
// Result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module wcdp_result_fifo
    import wcdp_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire push_t          push,
    input  wire logic           pop,
    output result_t             head,
    output logic                nonempty,
    output logic [RES_CNT_W-1:0] count
);

    result_t                mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]   count_reg,  count_next;
    logic [RES_PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + RES_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.v0) + RES_PTR_W'(push.v1);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push.v0) + RES_CNT_W'(push.v1)
                      - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_ptr_plus1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head     = mem[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign count    = count_reg;

endmodule

`default_nettype wire

// ----- src/webp_chunk_dimension_parser.sv -----
// ----------------------------------------------------------------------------
// webp_chunk_dimension_parser
// WebP chunk walker: reports image dimensions and the EXIF payload offset.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*) carries one file byte per word. s_tuser marks the
//   first byte of a file and restarts the parse; s_tlast marks the last byte.
//   Output stream (m_*) carries result words: m_tuser is the kind (dimensions,
//   EXIF found, end of file without EXIF), m_tlast flags the last word that a
//   given input byte caused. One byte can cause up to two words.
//   Timing: an accepted byte is parsed while it sits in the input register;
//   its result words are queued at the next edge and then show on m_* from
//   the queue. Throughput: one byte per cycle while s_tready is high; the
//   parse of a byte is a single pass of small logic between the input
//   register and the 8-word result queue.
//   Stall: while the receiver holds off, results wait in the queue and bytes
//   are still taken; s_tready drops once five or more words are queued.
//   Reset: rst_n clears the parse state and empties the queue; the next byte
//   is taken as the first of a file.
// ----------------------------------------------------------------------------
`default_nettype none

module webp_chunk_dimension_parser
    import wcdp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // file_start
    input  wire logic        s_tlast,   // file_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [24:0] image_width, [49:25] image_height, [81:50] exif_offset,
    // [82] exif_prefixed, [87:83] zero
    output logic [87:0]      m_tdata,
    output logic [1:0]       m_tuser,   // result_kind
    output logic             m_tlast    // end_of_run
);

    push_t                  push;
    result_t                head;
    logic                   nonempty;
    logic [RES_CNT_W-1:0]   count;
    logic                   in_accept;

    // room for the byte in the input register and the new one, two words each
    assign s_tready  = (count <= RES_CNT_W'(RES_DEPTH - 4));
    assign in_accept = s_tvalid && s_tready;

    wcdp_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_accept),
        .in_byte  (s_tdata),
        .in_start (s_tuser),
        .in_end   (s_tlast),
        .push     (push)
    );

    wcdp_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (m_tvalid && m_tready),
        .head     (head),
        .nonempty (nonempty),
        .count    (count)
    );

    assign m_tvalid = nonempty;
    assign m_tdata  = {5'd0, head.prefixed, head.offset, head.height, head.width};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule

`default_nettype wire

// ----- src/wcdp_checker.sv -----
// ----------------------------------------------------------------------------
// wcdp_checker
// Port-level checks on the result stream of the chunk parser.
// ----------------------------------------------------------------------------
`default_nettype none

module wcdp_checker
    import wcdp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                 && $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed under stall");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_DIMS || m_tuser == KIND_EXIF
                      || m_tuser == KIND_NO_EXIF))
        else $error("unknown result kind");

    // EXIF and end-of-file words always close their byte's run
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_DIMS |-> m_tlast)
        else $error("final result without end of run");

    a_no_dims: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_DIMS |-> m_tdata[49:0] == 50'd0)
        else $error("dimensions on a non-dimension result");

    a_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_EXIF |-> m_tdata[87:50] == 38'd0)
        else $error("offset or prefix on a non-EXIF result");

endmodule

bind webp_chunk_dimension_parser wcdp_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- verif/wcdp_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcdp_result_checker
// Watches both streams of the WebP chunk parser, predicts the result words of
// every accepted byte with its own chunk walker and compares them in order.
// ----------------------------------------------------------------------------
module wcdp_result_checker
    import wcdp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // file_start
    input  wire logic        s_tlast,   // file_end
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [24:0] image_width, [49:25] image_height, [81:50] exif_offset,
    // [82] exif_prefixed, [87:83] zero
    input  wire logic [87:0] m_tdata,
    input  wire logic [1:0]  m_tuser,   // result_kind
    input  wire logic        m_tlast,   // end_of_run
    output int               mismatches,
    output int               outstanding
);

    phase_t      phase;
    logic [3:0]  fcount;
    logic [31:0] tag_word;
    logic [31:0] chunk_len;
    logic [32:0] skip_left;
    logic [47:0] window;
    logic [31:0] pos;
    logic        dims_done;
    logic        exif_done;

    result_t     expected_reports[$];
    result_t     step_reports[$];
    int          fail_count = 0;

    function automatic void clear_parse();
        phase     = PH_HDR;
        fcount    = 4'd0;
        tag_word  = 32'd0;
        chunk_len = 32'd0;
        skip_left = 33'd0;
        window    = 48'd0;
        pos       = 32'd0;
        dims_done = 1'b0;
        exif_done = 1'b0;
    endfunction

    function automatic void note(input logic [1:0]  kind,
                                 input logic [24:0] w,
                                 input logic [24:0] h,
                                 input logic [31:0] off,
                                 input logic        pre);
        result_t r;
        r.kind     = kind;
        r.width    = w;
        r.height   = h;
        r.offset   = off;
        r.prefixed = pre;
        r.last     = 1'b0;
        step_reports.push_back(r);
    endfunction

    // remaining payload past what was read, plus the pad byte of an odd size
    function automatic void begin_skip(input logic [3:0] used);
        logic [32:0] rest;
        rest = (chunk_len > {28'd0, used}) ? ({1'b0, chunk_len} - {29'd0, used}) : 33'd0;
        skip_left = rest + {32'd0, chunk_len[0]};
        fcount    = 4'd0;
        phase     = (skip_left != 33'd0) ? PH_SKIP : PH_TAG;
    endfunction

    function automatic void enter_chunk();
        fcount = 4'd0;
        window = 48'd0;
        if (tag_word == TAG_VP8 && !dims_done)
            phase = PH_VP8;
        else if (tag_word == TAG_VP8L && !dims_done)
            phase = PH_VP8L;
        else if (tag_word == TAG_VP8X && !dims_done)
            phase = PH_VP8X;
        else if (tag_word == TAG_EXIF)
            phase = PH_EXIF;
        else
            begin_skip(4'd0);
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic fs, input logic fe);
        logic [31:0] dims_word;
        logic [31:0] tiff_at;
        logic        has_prefix;
        result_t     tail;
        step_reports.delete();
        if (fs)
            clear_parse();
        if (!exif_done)
        begin
            window = {b, window[47:8]};
            pos    = pos + 32'd1;
            case (phase)
                PH_HDR:
                begin
                    fcount = fcount + 4'd1;
                    if (fcount >= HDR_BYTES)
                    begin
                        fcount = 4'd0;
                        phase  = PH_TAG;
                    end
                end
                PH_TAG:
                begin
                    tag_word = {tag_word[23:0], b};
                    fcount   = fcount + 4'd1;
                    if (fcount >= TAG_BYTES)
                    begin
                        fcount = 4'd0;
                        phase  = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    chunk_len = {b, chunk_len[31:8]};
                    fcount    = fcount + 4'd1;
                    if (fcount >= TAG_BYTES)
                        enter_chunk();
                end
                PH_VP8:
                begin
                    fcount = fcount + 4'd1;
                    if (fcount >= VP8_BYTES)
                    begin
                        note(KIND_DIMS, {11'd0, window[29:16]}, {11'd0, window[45:32]},
                             32'd0, 1'b0);
                        dims_done = 1'b1;
                        begin_skip(VP8_BYTES);
                    end
                end
                PH_VP8L:
                begin
                    fcount = fcount + 4'd1;
                    if (fcount >= VP8L_BYTES)
                    begin
                        dims_word = window[47:16];
                        note(KIND_DIMS, {11'd0, dims_word[13:0]} + 25'd1,
                             {11'd0, dims_word[27:14]} + 25'd1, 32'd0, 1'b0);
                        dims_done = 1'b1;
                        begin_skip(VP8L_BYTES);
                    end
                end
                PH_VP8X:
                begin
                    fcount = fcount + 4'd1;
                    if (fcount >= VP8X_BYTES)
                    begin
                        note(KIND_DIMS, {1'b0, window[23:0]} + 25'd1,
                             {1'b0, window[47:24]} + 25'd1, 32'd0, 1'b0);
                        dims_done = 1'b1;
                        begin_skip(VP8X_BYTES);
                    end
                end
                PH_EXIF:
                begin
                    fcount = fcount + 4'd1;
                    if (fcount >= TAG_BYTES)
                    begin
                        has_prefix = (window[47:16] == WORD_EXIF);
                        tiff_at    = pos - 32'd4 + (has_prefix ? 32'd6 : 32'd0);
                        note(KIND_EXIF, 25'd0, 25'd0, tiff_at, has_prefix);
                        exif_done = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    if (skip_left != 33'd0)
                        skip_left = skip_left - 33'd1;
                    if (skip_left == 33'd0)
                        phase = PH_TAG;
                end
            endcase
        end
        if (fe)
        begin
            // ending inside the prefix still counts as an EXIF hit at the payload start
            if (!exif_done)
            begin
                if (phase == PH_EXIF)
                    note(KIND_EXIF, 25'd0, 25'd0, pos - {28'd0, fcount}, 1'b0);
                else
                    note(KIND_NO_EXIF, 25'd0, 25'd0, 32'd0, 1'b0);
            end
            clear_parse();
        end
        if (step_reports.size() != 0)
        begin
            tail      = step_reports.pop_back();
            tail.last = 1'b1;
            step_reports.push_back(tail);
        end
        foreach (step_reports[i])
            expected_reports.push_back(step_reports[i]);
    endtask

    function automatic string describe(input result_t r);
        return $sformatf("kind %0d w %0d h %0d off %08h pre %0b last %0b",
                         r.kind, r.width, r.height, r.offset, r.prefixed, r.last);
    endfunction

    task automatic check_word();
        result_t seen;
        result_t want;
        seen.kind     = m_tuser;
        seen.width    = m_tdata[24:0];
        seen.height   = m_tdata[49:25];
        seen.offset   = m_tdata[81:50];
        seen.prefixed = m_tdata[82];
        seen.last     = m_tlast;
        if (expected_reports.size() == 0)
        begin
            if (fail_count < 10)
                $display("%0t: result word with nothing expected: %s", $time, describe(seen));
            fail_count++;
        end
        else
        begin
            want = expected_reports.pop_front();
            if (seen.kind !== want.kind || seen.width !== want.width ||
                seen.height !== want.height || seen.offset !== want.offset ||
                seen.prefixed !== want.prefixed || seen.last !== want.last ||
                m_tdata[87:83] !== 5'd0)
            begin
                if (fail_count < 10)
                    $display("%0t: mismatch: expected %s / got %s pad %02h", $time,
                             describe(want), describe(seen), m_tdata[87:83]);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_reports.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                check_word();
        end
        mismatches  <= fail_count;
        outstanding <= expected_reports.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the WebP chunk parser with synthetic files: a directed set for the
// dimension forms, EXIF prefix handling, short chunks and file boundaries,
// then random files, mostly well formed, some cut short or pure noise. Both
// stream sides idle at random; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module testbench
    import wcdp_pkg::*;
();

    localparam logic [31:0] TAG_JUNK = 32'h4A55_4E4B;
    localparam int FILL_RAND  = 0;
    localparam int FILL_ONES  = 1;
    localparam int FILL_ZEROS = 2;
    localparam int FILL_EXIF  = 3;
    localparam int WORD_TARGET = 1400;
    localparam int HOLD_CYCLES = 600;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          mismatches;
    int          outstanding;

    logic [7:0]  file_bytes[$];
    int          file_live;
    int          live_sent = 0;
    logic        steady = 1'b0;
    logic        hold_active = 1'b0;
    logic        hold_done = 1'b0;

    webp_chunk_dimension_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    wcdp_result_checker u_result_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || hold_active)
            return 0;
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic fs, input logic fe);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fs;
        s_tlast  <= fe;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic void new_file();
        file_bytes.delete();
        file_live = 1 << 30;
    endfunction

    function automatic void put_random(input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_chunk(input logic [31:0] tag, input logic [31:0] size,
                                      input int fill);
        int body;
        int floor_len;
        logic [7:0] b;
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(tag[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(size[8*i +: 8]);
        // bytes past the fourth EXIF payload byte are ignored by the block
        if (tag == TAG_EXIF && file_live > file_bytes.size() + 4)
            file_live = file_bytes.size() + 4;
        floor_len = 0;
        if (tag == TAG_VP8 || tag == TAG_VP8X)
            floor_len = 10;
        else if (tag == TAG_VP8L)
            floor_len = 5;
        else if (fill == FILL_EXIF)
            floor_len = 6;
        // huge sizes are cut; the caller ends the file right after
        body = (size > 32'd64) ? 16 : int'(size);
        if (body < floor_len)
            body = floor_len;
        if (size[0] && size <= 32'd64)
            body++;
        for (int i = 0; i < body; i++)
        begin
            case (fill)
                FILL_ONES:  b = 8'hFF;
                FILL_ZEROS: b = 8'h00;
                FILL_EXIF:  b = (i < 4) ? WORD_EXIF[8*i +: 8] : (i < 6) ? 8'h00 : 8'($urandom);
                default:    b = 8'($urandom);
            endcase
            file_bytes.push_back(b);
        end
    endfunction

    task automatic ship(input logic fs, input logic fe, input int keep);
        for (int i = 0; i < keep; i++)
        begin
            send_word(file_bytes[i], fs && i == 0, fe && i == keep - 1);
            if (i < file_live)
                live_sent++;
        end
    endtask

    task automatic random_file();
        int r;
        int nchunks;
        int keep;
        int fill;
        logic [31:0] tag;
        logic [31:0] size;
        new_file();
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 12)
        begin
            // noise: random bytes with random file markers
            repeat ($urandom_range(1, 24))
            begin
                send_word(8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
                live_sent++;
            end
            return;
        end
        put_random(12);
        nchunks = $urandom_range(1, 3);
        for (int k = 0; k < nchunks; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                tag = TAG_VP8;
            else if (r < 45)
                tag = TAG_VP8L;
            else if (r < 65)
                tag = TAG_VP8X;
            else if (r < 80)
                tag = TAG_EXIF;
            else
                tag = $urandom;
            r = $urandom_range(0, 99);
            if (r < 8)
                size = $urandom;
            else if (r < 20)
                size = $urandom_range(0, 9);
            else
                size = $urandom_range(0, 24);
            r = $urandom_range(0, 99);
            if (tag == TAG_EXIF)
                fill = (r < 65) ? FILL_EXIF : FILL_RAND;
            else
                fill = (r < 10) ? FILL_ONES : (r < 20) ? FILL_ZEROS : FILL_RAND;
            put_chunk(tag, size, fill);
            if (size > 32'd64)
                break;
            if (tag == TAG_EXIF)
            begin
                put_random($urandom_range(0, 4));
                break;
            end
        end
        keep = file_bytes.size();
        if ($urandom_range(0, 4) == 0)
            keep = $urandom_range(1, keep);
        ship($urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0, keep);
    endtask

    // receiver: random ready pattern, one long hold-off while the sender pushes
    initial
    begin
        int r;
        int len;
        logic level;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!hold_done && live_sent >= 300)
            begin
                hold_active = 1'b1;
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    level = 1'b1;
                    len   = $urandom_range(1, 8);
                end
                else if (r < 65)
                begin
                    level = 1'b1;
                    len   = $urandom_range(20, 120);
                end
                else if (r < 95)
                begin
                    level = 1'b0;
                    len   = $urandom_range(1, 3);
                end
                else
                begin
                    level = 1'b0;
                    len   = $urandom_range(10, 40);
                end
                @(negedge clk);
                m_tready <= level;
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        int waited;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // field maxima through VP8, prefixed EXIF, then bytes that get dropped
        new_file();
        put_random(12);
        put_chunk(TAG_VP8, 32'd10, FILL_ONES);
        put_chunk(TAG_EXIF, 32'd8, FILL_EXIF);
        put_random(3);
        ship(1'b1, 1'b1, file_bytes.size());

        // VP8L at maximum, unknown odd chunk, no file_start after a file end
        new_file();
        put_random(12);
        put_chunk(TAG_VP8L, 32'd5, FILL_ONES);
        put_chunk(TAG_JUNK, 32'd3, FILL_RAND);
        ship(1'b0, 1'b1, file_bytes.size());

        // VP8X at maximum, later VP8 chunk skipped, ends without EXIF
        new_file();
        put_random(12);
        put_chunk(TAG_VP8X, 32'd10, FILL_ONES);
        put_chunk(TAG_VP8, 32'd10, FILL_ZEROS);
        ship(1'b1, 1'b1, file_bytes.size());

        // minimum dimensions and an EXIF payload with no prefix
        new_file();
        put_random(12);
        put_chunk(TAG_VP8X, 32'd10, FILL_ZEROS);
        put_chunk(TAG_EXIF, 32'd6, FILL_ZEROS);
        ship(1'b1, 1'b1, file_bytes.size());

        // short dimension chunks, odd and even
        new_file();
        put_random(12);
        put_chunk(TAG_VP8, 32'd3, FILL_RAND);
        put_chunk(TAG_EXIF, 32'd5, FILL_RAND);
        ship(1'b1, 1'b1, file_bytes.size());
        new_file();
        put_random(12);
        put_chunk(TAG_VP8L, 32'd2, FILL_ZEROS);
        put_chunk(TAG_VP8X, 32'd7, FILL_RAND);
        ship(1'b1, 1'b1, file_bytes.size());

        // end inside the EXIF prefix
        new_file();
        put_random(12);
        put_chunk(TAG_EXIF, 32'd6, FILL_EXIF);
        ship(1'b1, 1'b1, 22);

        // one-byte file with both markers
        new_file();
        put_random(1);
        ship(1'b1, 1'b1, 1);

        // end on the last dimension byte: two words from one byte
        new_file();
        put_random(12);
        put_chunk(TAG_VP8, 32'd10, FILL_RAND);
        ship(1'b1, 1'b1, 30);

        // abandon a file mid-chunk, restart with file_start
        new_file();
        put_random(12);
        put_chunk(TAG_VP8X, 32'd10, FILL_RAND);
        ship(1'b1, 1'b0, 15);

        // huge chunk size, file ends while skipping
        new_file();
        put_random(12);
        put_chunk(TAG_JUNK, 32'hFFFF_FFFF, FILL_RAND);
        ship(1'b1, 1'b1, file_bytes.size());

        while (live_sent < WORD_TARGET)
            random_file();

        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (outstanding != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
src/wcdp_pkg.sv
src/wcdp_parser.sv
src/wcdp_result_fifo.sv
src/webp_chunk_dimension_parser.sv
src/wcdp_checker.sv
verif/wcdp_result_checker.sv
verif/testbench.sv
